// File: rtl/dc_master_clock_drift_filter_top_assert.svh
// Assertion macros for the drift filter. Each macro takes a label, a
// condition and a consequence, and uses the clk and rst of the module
// that includes this file.
`ifndef DC_MASTER_CLOCK_DRIFT_FILTER_TOP_ASSERT_SVH
`define DC_MASTER_CLOCK_DRIFT_FILTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define DCDF_ASSERT_IMPLY(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("drift filter check failed");
`define DCDF_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("drift filter check failed");
`else
`define DCDF_ASSERT_IMPLY(lbl, cond, cons)
`define DCDF_ASSERT_NEXT(lbl, cond, cons)
`endif

`endif

// File: rtl/dcdf_pkg.sv
package dcdf_pkg;

  // Averaging window length; a power of two, so the mean is a shift.
  localparam int FILTER_COUNT = 1024;
  localparam int FC_LOG       = $clog2(FILTER_COUNT);
  localparam int CNT_W        = FC_LOG;
  // Sums over one window of 32-bit values, plus a sign bit.
  localparam int SUM_W        = 32 + FC_LOG + 1;
  localparam int ADJ_W        = 11;
  localparam int ADJ_LIMIT    = 1000;
  localparam int CP_W         = 30;
  localparam int DIV_STEPS    = 32;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam int IN_W         = 64;
  localparam int OUT_W        = 120;

  // Commands from the controller to the datapath; at most one is high.
  typedef struct packed {
    logic capture;
    logic prep;
    logic div_step;
    logic norm_acc;
    logic win_add;
    logic win_quot;
    logic win_sum;
    logic win_clamp;
    logic base_upd;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic started;
    logic win_last;
  } stat_t;

endpackage

// File: rtl/dcdf_ctrl.sv
module dcdf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           out_free,
  input  dcdf_pkg::stat_t stat,
  output dcdf_pkg::cmd_t  cmd
);
  import dcdf_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_NORM  = 4'd3;
  localparam logic [3:0] S_WIN1  = 4'd4;
  localparam logic [3:0] S_WIN2  = 4'd5;
  localparam logic [3:0] S_WIN3  = 4'd6;
  localparam logic [3:0] S_WIN4  = 4'd7;
  localparam logic [3:0] S_STEP  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  logic [3:0]           state;
  logic [3:0]           state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DIV_CNT_W-1:0] div_cnt_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep     = 1'b1;
        div_cnt_next = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_LAST) begin
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        cmd.norm_acc = 1'b1;
        state_next   = (stat.started && stat.win_last) ? S_WIN1 : S_STEP;
      end
      S_WIN1: begin
        cmd.win_add = 1'b1;
        state_next  = S_WIN2;
      end
      S_WIN2: begin
        cmd.win_quot = 1'b1;
        state_next   = S_WIN3;
      end
      S_WIN3: begin
        cmd.win_sum = 1'b1;
        state_next  = S_WIN4;
      end
      S_WIN4: begin
        cmd.win_clamp = 1'b1;
        state_next    = S_STEP;
      end
      S_STEP: begin
        cmd.base_upd = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

endmodule

// File: rtl/dcdf_dp.sv
module dcdf_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  dcdf_pkg::cmd_t                cmd,
  output dcdf_pkg::stat_t               stat,
  input  logic [31:0]                   app_time_low,
  input  logic [31:0]                   reference_time,
  input  logic [dcdf_pkg::CP_W-1:0]     cycle_period,
  input  logic                          init_load,
  input  logic [31:0]                   init_value,
  output logic signed [31:0]            normalised_diff,
  output logic signed [dcdf_pkg::ADJ_W-1:0] drift_adjust,
  output logic signed [dcdf_pkg::ADJ_W-1:0] base_step,
  output logic signed [63:0]            time_base,
  output logic                          locked
);
  import dcdf_pkg::*;

  localparam logic signed [SUM_W-1:0] FC_S     = SUM_W'(FILTER_COUNT);
  localparam logic signed [SUM_W-1:0] FC_HALF  = SUM_W'(FILTER_COUNT / 2);
  localparam logic signed [SUM_W-1:0] FC_MASK  = SUM_W'(FILTER_COUNT - 1);
  localparam logic signed [SUM_W-1:0] LIM_HI   = SUM_W'(ADJ_LIMIT);
  localparam logic signed [SUM_W-1:0] LIM_LO   = -SUM_W'(ADJ_LIMIT);
  localparam logic [CNT_W-1:0]        CNT_LAST = CNT_W'(FILTER_COUNT - 1);

  logic [31:0]              last_app;
  logic [31:0]              last_raw;
  logic [31:0]              raw;
  logic signed [31:0]       delta;
  logic [CP_W-2:0]          half;
  logic [31:0]              dvd;
  logic [31:0]              rem;
  logic                     started;
  logic                     act;
  logic signed [SUM_W-1:0]  diff_sum;
  logic signed [SUM_W-1:0]  delta_sum;
  logic [CNT_W-1:0]         win_cnt;
  logic signed [SUM_W-1:0]  wide;
  logic signed [1:0]        dsgn;
  logic signed [ADJ_W-1:0]  adj;

  logic [31:0]              raw_next;
  logic [31:0]              rem_sh;
  logic [31:0]              norm_next;
  logic signed [ADJ_W-1:0]  step_next;
  logic signed [ADJ_W-1:0]  norm_sgn;

  assign raw_next = last_app - reference_time;
  // Restoring remainder step. With a zero divisor every step keeps the
  // shifted bit, so the remainder ends equal to the dividend.
  assign rem_sh   = {rem[30:0], dvd[31]};
  assign norm_next = rem - {{(32 - (CP_W - 1)){1'b0}}, half};
  assign norm_sgn = (normalised_diff > 0) ? ADJ_W'(1) :
                    (normalised_diff < 0) ? -ADJ_W'(1) : '0;
  assign step_next = act ? (adj + norm_sgn) : '0;

  assign stat.started  = started;
  assign stat.win_last = (win_cnt == CNT_LAST);

  assign drift_adjust = adj;
  assign locked       = started;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_app  <= '0;
      last_raw  <= '0;
      started   <= 1'b0;
      diff_sum  <= '0;
      delta_sum <= '0;
      win_cnt   <= '0;
      adj       <= '0;
      time_base <= '0;
    end else begin
      if (init_load) begin
        last_app <= init_value;
      end
      if (cmd.capture) begin
        last_app <= app_time_low;
        last_raw <= raw_next;
        raw      <= raw_next;
        delta    <= raw_next - last_raw;
        half     <= cycle_period[CP_W-1:1];
      end
      if (cmd.prep) begin
        dvd <= raw + {{(32 - (CP_W - 1)){1'b0}}, half};
        rem <= '0;
      end
      if (cmd.div_step) begin
        dvd <= {dvd[30:0], 1'b0};
        if (rem_sh >= {{(32 - CP_W){1'b0}}, cycle_period}) begin
          rem <= rem_sh - {{(32 - CP_W){1'b0}}, cycle_period};
        end else begin
          rem <= rem_sh;
        end
      end
      if (cmd.norm_acc) begin
        normalised_diff <= norm_next;
        act             <= started;
        if (started) begin
          diff_sum  <= diff_sum + {{(SUM_W - 32){norm_next[31]}}, norm_next};
          delta_sum <= delta_sum + {{(SUM_W - 32){delta[31]}}, delta};
          win_cnt   <= stat.win_last ? '0 : win_cnt + 1'b1;
        end else begin
          started <= (norm_next != '0);
        end
      end
      if (cmd.win_add) begin
        wide      <= delta_sum + FC_HALF;
        dsgn      <= (diff_sum >= FC_S) ? 2'sd1 : (diff_sum <= -FC_S) ? -2'sd1 : 2'sd0;
        diff_sum  <= '0;
        delta_sum <= '0;
      end
      if (cmd.win_quot) begin
        // Division toward zero: bias negative values before the shift.
        wide <= $signed(wide + (wide[SUM_W-1] ? FC_MASK : '0)) >>> FC_LOG;
      end
      if (cmd.win_sum) begin
        wide <= {{(SUM_W - ADJ_W){adj[ADJ_W-1]}}, adj} + wide
                + {{(SUM_W - 2){dsgn[1]}}, dsgn};
      end
      if (cmd.win_clamp) begin
        if (wide > LIM_HI) begin
          adj <= ADJ_W'(ADJ_LIMIT);
        end else if (wide < LIM_LO) begin
          adj <= -ADJ_W'(ADJ_LIMIT);
        end else begin
          adj <= wide[ADJ_W-1:0];
        end
      end
      if (cmd.base_upd) begin
        base_step <= step_next;
        time_base <= time_base + {{(64 - ADJ_W){step_next[ADJ_W-1]}}, step_next};
      end
    end
  end

endmodule

// File: rtl/dc_master_clock_drift_filter_top.sv
// Master-to-reference clock drift filter. Each input word is one bus cycle:
// the low 32 bits of the application time and the reference clock time read
// in that cycle. The block forms the previous application time minus the
// reference time, folds it into one cycle period around zero, and once a
// nonzero folded difference has been seen it averages differences and
// difference deltas over windows of 1024 input words to steer a clamped
// per-cycle drift adjustment (within -1000..1000 ns) and a wrapping 64-bit
// time base. Every input word yields exactly one output word. An accepted
// item is captured, folded by a bit-serial remainder unit that divides by
// the cycle period, accumulated, passed through the window update at the
// end of an averaging window, and applied to the time base. The output
// register holds one finished word, so the next input is taken as soon as
// the result has moved into it. Configuration must be written through the
// APB port only while no item is in flight; the block does not enforce this.
// Writing initial_app_time also reloads the stored previous application time.
`include "dc_master_clock_drift_filter_top_assert.svh"

module dc_master_clock_drift_filter_top (
  input  logic         clk,
  input  logic         rst,
  // Input words.
  input  logic         s_tvalid,
  output logic         s_tready,
  // app_time_low [31:0], reference_time [63:32]
  input  logic [63:0]  s_tdata,
  // Result words.
  output logic         m_tvalid,
  input  logic         m_tready,
  // normalised_diff [31:0], drift_adjust [42:32], base_step [53:43],
  // time_base [117:54], locked [118], zero [119]
  output logic [119:0] m_tdata,
  // Register port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import dcdf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  logic [CP_W-1:0] cycle_period;
  logic [31:0]     initial_app_time;
  logic            wr_en;
  logic            init_load;
  logic            out_free;

  logic signed [31:0]       normalised_diff;
  logic signed [ADJ_W-1:0]  drift_adjust;
  logic signed [ADJ_W-1:0]  base_step;
  logic signed [63:0]       time_base;
  logic                     locked;

  // Register map: cycle_period at byte 0, initial_app_time at byte 4.
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;
  assign init_load = wr_en && paddr[2];
  assign prdata    = paddr[2] ? initial_app_time
                              : {{(32 - CP_W){1'b0}}, cycle_period};

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_period     <= CP_W'(1000000);
      initial_app_time <= '0;
    end else if (wr_en) begin
      if (paddr[2]) begin
        initial_app_time <= pwdata;
      end else begin
        cycle_period <= pwdata[CP_W-1:0];
      end
    end
  end

  // The output register frees up when it is empty or being read out.
  assign out_free = !m_tvalid || m_tready;

  dcdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd)
  );

  dcdf_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .app_time_low    (s_tdata[31:0]),
    .reference_time  (s_tdata[63:32]),
    .cycle_period    (cycle_period),
    .init_load       (init_load),
    .init_value      (pwdata),
    .normalised_diff (normalised_diff),
    .drift_adjust    (drift_adjust),
    .base_step       (base_step),
    .time_base       (time_base),
    .locked          (locked)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {1'b0, locked, time_base, base_step, drift_adjust, normalised_diff};
    end
  end

  // Once an item is taken the block is busy for at least the next cycle.
  `DCDF_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  // The filter never leaves the started condition.
  `DCDF_ASSERT_NEXT(a_lock_holds, stat.started, stat.started)
  // Every published adjustment is inside the clamp limits.
  `DCDF_ASSERT_IMPLY(a_adjust_range, cmd.out_load,
    (drift_adjust <= ADJ_W'(ADJ_LIMIT)) && (drift_adjust >= -ADJ_W'(ADJ_LIMIT)))
  // A result is only moved into a free output register.
  `DCDF_ASSERT_IMPLY(a_no_overwrite, cmd.out_load, out_free)

endmodule
